FILE: src/vas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vas_pkg
// Shared types, codes, voice orders and control structs for the voice
// allocator with stealing.
// ----------------------------------------------------------------------------
package vas_pkg;

	localparam int VOICE_COUNT = 16;
	localparam int VOICE_W     = $clog2(VOICE_COUNT);
	localparam int LEN_W       = $clog2(VOICE_COUNT + 1);

	typedef enum logic [1:0] {
		OP_SET       = 2'd0,
		OP_RESERVE   = 2'd1,
		OP_UNRESERVE = 2'd2,
		OP_ALLOCATE  = 2'd3
	} vas_op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_VOICE = 2'd1,
		ST_CONFLICT = 2'd2,
		ST_BAD_KIND = 2'd3
	} vas_status_t;

	typedef enum logic [1:0] {
		KIND_PCM   = 2'd0,
		KIND_PULSE = 2'd1,
		KIND_NOISE = 2'd2,
		KIND_NONE  = 2'd3
	} vas_kind_t;

	// Voice status codes. Code three is stored as given and acts as sounding.
	localparam logic [1:0] VS_FREE      = 2'd0;
	localparam logic [1:0] VS_RELEASING = 2'd1;
	localparam logic [1:0] VS_SOUNDING  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_SCAN = 2'd2,
		S_DONE = 2'd3
	} vas_state_t;

	localparam logic [VOICE_W-1:0] PCM_ORDER [16] = '{
		4'd4, 4'd5, 4'd6, 4'd7, 4'd2, 4'd0, 4'd3, 4'd1,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd14, 4'd12, 4'd15, 4'd13
	};
	localparam logic [VOICE_W-1:0] PULSE_ORDER [6] = '{
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13
	};
	localparam logic [VOICE_W-1:0] NOISE_ORDER [2] = '{
		4'd14, 4'd15
	};

	// Controller to datapath.
	typedef struct packed {
		logic load_item;
		logic exec;
		logic scan_step;
		logic load_out;
	} vas_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_alloc;
		logic kind_ok;
		logic scan_last;
	} vas_stat_t;

	function automatic logic [VOICE_W-1:0] voice_at(input vas_kind_t kind,
			input logic [VOICE_W-1:0] idx);
		logic [VOICE_W-1:0] v;
		v = '0;
		unique case (kind)
			KIND_PCM:   v = PCM_ORDER[idx];
			KIND_PULSE: v = (idx[2:0] < 3'd6) ? PULSE_ORDER[idx[2:0]] : '0;
			KIND_NOISE: v = NOISE_ORDER[idx[0]];
			default:    v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [LEN_W-1:0] order_len(input vas_kind_t kind);
		logic [LEN_W-1:0] n;
		n = '0;
		unique case (kind)
			KIND_PCM:   n = LEN_W'(16);
			KIND_PULSE: n = LEN_W'(6);
			KIND_NOISE: n = LEN_W'(2);
			default:    n = '0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: src/vas_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vas_item_if
// Input channel: one request word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vas_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [3:0]  voice_index;
	logic [1:0]  voice_status;
	logic [7:0]  owner_priority;
	logic signed [15:0] voice_level;
	logic [1:0]  instrument_kind;
	logic [7:0]  request_priority;
	logic [15:0] allowed_mask;

	modport source (
		output valid, opcode, voice_index, voice_status, owner_priority,
		       voice_level, instrument_kind, request_priority, allowed_mask,
		input  ready
	);
	modport sink (
		input  valid, opcode, voice_index, voice_status, owner_priority,
		       voice_level, instrument_kind, request_priority, allowed_mask,
		output ready
	);
endinterface
`default_nettype wire

FILE: src/vas_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vas_result_if
// Output channel: one result word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vas_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] chosen_voice;

	modport source (output valid, status, chosen_voice, input ready);
	modport sink (input valid, status, chosen_voice, output ready);
endinterface
`default_nettype wire

FILE: src/vas_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vas_ctrl
// Sequencer: accepts a word, runs the table update or the voice scan, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module vas_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire vas_pkg::vas_stat_t stat,
	output vas_pkg::vas_cmd_t  cmd
);
	import vas_pkg::*;

	vas_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.is_alloc && stat.kind_ok)
					state_d = S_SCAN;
				else
					state_d = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last)
					state_d = S_DONE;
			end
			S_DONE: begin
				// The result waits here until the output register is free.
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: src/vas_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vas_datapath
// Voice tables, reservation mask, one-voice-per-cycle scan and result
// register.
// ----------------------------------------------------------------------------
module vas_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vas_pkg::vas_cmd_t cmd,
	output vas_pkg::vas_stat_t stat,
	input  wire logic [1:0]    opcode,
	input  wire logic [3:0]    voice_index,
	input  wire logic [1:0]    voice_status,
	input  wire logic [7:0]    owner_priority,
	input  wire logic signed [15:0] voice_level,
	input  wire logic [1:0]    instrument_kind,
	input  wire logic [7:0]    request_priority,
	input  wire logic [15:0]   allowed_mask,
	output logic [1:0]         status,
	output logic [3:0]         chosen_voice
);
	import vas_pkg::*;

	// Captured request word.
	vas_op_t            op_q;
	logic [VOICE_W-1:0] vidx_q;
	logic [1:0]         vstat_q;
	logic [7:0]         opri_q;
	logic signed [15:0] lvl_q;
	vas_kind_t          kind_q;
	logic [7:0]         req_q;
	logic [15:0]        mask_q;

	// Voice state.
	logic [1:0]         stat_tab_q [VOICE_COUNT];
	logic [7:0]         pri_tab_q  [VOICE_COUNT];
	logic signed [15:0] lvl_tab_q  [VOICE_COUNT];
	logic [VOICE_COUNT-1:0] rsv_q;

	// Scan state.
	logic [VOICE_W-1:0] idx_q;
	logic               err_q;
	logic               free_hit_q, rel_hit_q, best_hit_q;
	logic [VOICE_W-1:0] free_v_q, rel_v_q, best_v_q;
	logic [7:0]         best_pri_q;
	logic signed [15:0] best_lvl_q;

	logic [1:0]         res_status_q;
	logic [VOICE_W-1:0] res_voice_q;

	logic [VOICE_W-1:0] cur_v;
	logic               cur_ok;
	logic [1:0]         cur_stat;
	logic [7:0]         cur_pri;
	logic signed [15:0] cur_lvl;
	logic               take_best;
	logic [LEN_W-1:0]   len;
	vas_status_t        res_status;
	logic [VOICE_W-1:0] res_voice;

	always_comb begin
		cur_v    = voice_at(kind_q, idx_q);
		cur_stat = stat_tab_q[cur_v];
		cur_pri  = pri_tab_q[cur_v];
		cur_lvl  = lvl_tab_q[cur_v];
		cur_ok   = ((mask_q == '0) || mask_q[cur_v]) && !rsv_q[cur_v];
		// Lower owner priority wins; on a tie the louder voice wins.
		if (!best_hit_q)
			take_best = cur_pri < req_q;
		else
			take_best = (cur_pri < best_pri_q) ||
			            ((cur_pri == best_pri_q) && (cur_lvl > best_lvl_q));
		len = order_len(kind_q);
	end

	assign stat.is_alloc  = (op_q == OP_ALLOCATE);
	assign stat.kind_ok   = (kind_q != KIND_NONE);
	assign stat.scan_last = ({1'b0, idx_q} == (len - LEN_W'(1)));

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q    <= vas_op_t'(opcode);
			vidx_q  <= voice_index;
			vstat_q <= voice_status;
			opri_q  <= owner_priority;
			lvl_q   <= voice_level;
			kind_q  <= vas_kind_t'(instrument_kind);
			req_q   <= request_priority;
			mask_q  <= allowed_mask;
		end
		if (cmd.scan_step) begin
			if (cur_ok && cur_stat == VS_FREE && !free_hit_q)
				free_v_q <= cur_v;
			if (cur_ok && cur_stat == VS_RELEASING && !rel_hit_q)
				rel_v_q <= cur_v;
			if (cur_ok && take_best) begin
				best_v_q   <= cur_v;
				best_pri_q <= cur_pri;
				best_lvl_q <= cur_lvl;
			end
		end
		if (cmd.load_out) begin
			res_status_q <= res_status;
			res_voice_q  <= res_voice;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICE_COUNT; i++) begin
				stat_tab_q[i] <= VS_FREE;
				pri_tab_q[i]  <= '0;
				lvl_tab_q[i]  <= '0;
			end
			rsv_q      <= '0;
			idx_q      <= '0;
			err_q      <= 1'b0;
			free_hit_q <= 1'b0;
			rel_hit_q  <= 1'b0;
			best_hit_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				idx_q      <= '0;
				err_q      <= 1'b0;
				free_hit_q <= 1'b0;
				rel_hit_q  <= 1'b0;
				best_hit_q <= 1'b0;
			end
			if (cmd.exec) begin
				case (op_q)
					OP_SET: begin
						stat_tab_q[vidx_q] <= vstat_q;
						pri_tab_q[vidx_q]  <= opri_q;
						lvl_tab_q[vidx_q]  <= lvl_q;
					end
					OP_RESERVE: begin
						if (rsv_q[vidx_q])
							err_q <= 1'b1;
						else
							rsv_q[vidx_q] <= 1'b1;
					end
					OP_UNRESERVE: begin
						if (!rsv_q[vidx_q])
							err_q <= 1'b1;
						else
							rsv_q[vidx_q] <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + VOICE_W'(1);
				if (cur_ok && cur_stat == VS_FREE)
					free_hit_q <= 1'b1;
				if (cur_ok && cur_stat == VS_RELEASING)
					rel_hit_q <= 1'b1;
				if (cur_ok && take_best)
					best_hit_q <= 1'b1;
			end
		end
	end

	// Free beats releasing, which beats stealing.
	always_comb begin
		res_status = ST_OK;
		res_voice  = '0;
		if (op_q == OP_ALLOCATE) begin
			if (kind_q == KIND_NONE)
				res_status = ST_BAD_KIND;
			else if (free_hit_q)
				res_voice = free_v_q;
			else if (rel_hit_q)
				res_voice = rel_v_q;
			else if (best_hit_q)
				res_voice = best_v_q;
			else
				res_status = ST_NO_VOICE;
		end else if (err_q) begin
			res_status = ST_CONFLICT;
		end
	end

	assign status       = res_status_q;
	assign chosen_voice = res_voice_q;

endmodule
`default_nettype wire

FILE: src/voice_allocator_with_stealing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voice_allocator_with_stealing
// Sixteen-voice allocator with priority-based voice stealing.
// ----------------------------------------------------------------------------
// Each accepted word gives exactly one result word. A set, reserve or
// unreserve word runs through the exec and done states, its result is
// loaded into the output register, and the block then returns to idle
// for the next word. An allocation scans the voice order of its
// instrument kind one voice per cycle through the voice tables, tracking
// the first free voice, the first releasing voice and the best steal
// candidate in the same pass. The order holds 16 voices for pcm, 6 for
// pulse, 2 for noise and none for an unsupported kind, which skips the
// scan. The block works on one word at a time and takes the next word as
// soon as the finished result sits in the output register, even if the
// sink has not yet taken it; a finished result that finds the output
// register still full holds the block until the sink takes the older word.
module voice_allocator_with_stealing (
	input wire logic     clk,
	input wire logic     arst_n,
	vas_item_if.sink     item,
	vas_result_if.source result
);
	import vas_pkg::*;

	vas_cmd_t  cmd;
	vas_stat_t stat;

	vas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vas_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.opcode           (item.opcode),
		.voice_index      (item.voice_index),
		.voice_status     (item.voice_status),
		.owner_priority   (item.owner_priority),
		.voice_level      (item.voice_level),
		.instrument_kind  (item.instrument_kind),
		.request_priority (item.request_priority),
		.allowed_mask     (item.allowed_mask),
		.status           (result.status),
		.chosen_voice     (result.chosen_voice)
	);

endmodule
`default_nettype wire
